// ----- rtl/mlss_pkg.sv -----
`default_nettype none
package mlss_pkg;

  localparam int PORT_BYTES_DEF = 4;
  localparam int REG_BITS_DEF   = 64;
  localparam int ADDR_BITS_DEF  = 32;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [3:0] OP_READ  = 4'd0;
  localparam logic [3:0] OP_WRITE = 4'd1;

  localparam logic REQ_CORE = 1'b0;
  localparam logic REQ_RESP = 1'b1;

  typedef enum logic [2:0] {
    KIND_BEAT  = 3'd0,
    KIND_WB    = 3'd1,
    KIND_DONE  = 3'd2,
    KIND_FAULT = 3'd3,
    KIND_BUSY  = 3'd4
  } kind_t;

  typedef struct packed {
    logic        req_type;
    logic [31:0] addr;
    logic [3:0]  size;
    logic [3:0]  op_kind;
    logic        sign_ext;
    logic [4:0]  dest_reg;
    logic [4:0]  result_reg;
    logic [63:0] store_data;
    logic [31:0] pc;
    logic [63:0] resp_data;
    logic [63:0] resp_old_value;
    logic        resp_error;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  out_kind;
    logic [31:0] beat_addr;
    logic [3:0]  beat_size;
    logic [3:0]  beat_op;
    logic [63:0] beat_data;
    logic        is_split;
    logic [4:0]  wb_reg;
    logic [63:0] wb_data;
    logic [31:0] fault_pc;
    logic [31:0] fault_addr;
    logic [3:0]  fault_size;
    logic [3:0]  fault_op;
  } out_item_t;

  // classified work handed from front to back
  typedef struct packed {
    kind_t       kind;
    logic [31:0] addr;
    logic [3:0]  size;
    logic [3:0]  op;
    logic        split;
    logic        sgn;
    logic [4:0]  reg_idx;
    logic [3:0]  b0;
    logic [3:0]  b1;
    logic [63:0] d0;
    logic [63:0] d1;
    logic [31:0] pc;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic pending;
  } front_status_t;

  function automatic logic [63:0] bmask(input logic [3:0] n);
    logic [63:0] m;
    if (n >= 4'd8) begin
      m = '1;
    end else begin
      m = (64'd1 << {n[2:0], 3'b000}) - 64'd1;
    end
    return m;
  endfunction

  function automatic logic [63:0] extend_bytes(input logic [63:0] v, input logic [3:0] n,
                                               input logic sgn);
    logic [63:0] m;
    logic [63:0] r;
    logic [5:0]  sb;
    m  = bmask(n);
    r  = v & m;
    sb = {n[2:0], 3'b000} - 6'd1;
    if (sgn && (n != 4'd0) && (n < 4'd8) && r[sb]) begin
      r = r | ~m;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/mlss_front.sv -----
`default_nettype none
module mlss_front #(
  parameter int PORT_BYTES = mlss_pkg::PORT_BYTES_DEF,
  parameter int REG_BITS   = mlss_pkg::REG_BITS_DEF,
  parameter int ADDR_BITS  = mlss_pkg::ADDR_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    accept,
  input  mlss_pkg::in_item_t      in_data,
  output mlss_pkg::cmd_t          cmd,
  output logic                    cmd_valid,
  output mlss_pkg::front_status_t status
);
  import mlss_pkg::*;

  localparam int AW = ADDR_BITS;
  localparam int RW = REG_BITS;

  // residue mod port width: fold bit weights, then a small constant table
  function automatic logic [2:0] mod_port(input logic [AW-1:0] x);
    logic [8:0] s1;
    logic [5:0] s2;
    logic [2:0] r;
    s1 = '0;
    for (int i = 0; i < AW; i++) begin
      if (x[i]) s1 = s1 + 9'(((64'd1 << i) % PORT_BYTES));
    end
    s2 = '0;
    for (int j = 0; j < 9; j++) begin
      if (s1[j]) s2 = s2 + 6'(((64'd1 << j) % PORT_BYTES));
    end
    r = '0;
    for (int k = 0; k < 64; k++) begin
      if (s2 == 6'(k)) r = 3'(k % PORT_BYTES);
    end
    return r;
  endfunction

  logic          busy_r, busy_nxt;
  logic          pend_r, pend_nxt;
  logic [AW-1:0] addr2_r, addr2_nxt;
  logic [3:0]    b0_r, b0_nxt;
  logic [3:0]    b1_r, b1_nxt;
  logic [RW-1:0] saved_r, saved_nxt;
  logic [3:0]    op_r, op_nxt;
  logic          sgn_r, sgn_nxt;
  logic [4:0]    treg_r, treg_nxt;
  logic [4:0]    areg_r, areg_nxt;
  logic [31:0]   pc_r, pc_nxt;

  logic [AW-1:0] a, last, ws_a, ws_last, span, fa;
  logic [3:0]    sz, s0, fs;
  logic          split;
  logic [63:0]   data_lo, old_lo;

  always_comb begin
    a = AW'(in_data.addr);
    if (in_data.size == 4'd0) begin
      sz = 4'd1;
    end else if (in_data.size > 4'd8) begin
      sz = 4'd8;
    end else begin
      sz = in_data.size;
    end
    last    = a + AW'(sz) - AW'(1);
    ws_a    = a - AW'(mod_port(a));
    ws_last = last - AW'(mod_port(last));
    span    = ws_last - a;
    split   = (ws_a != ws_last) && (span != '0) && (span < AW'(sz));
    s0      = span[3:0];
    fa      = pend_r ? (addr2_r - AW'(b0_r)) : addr2_r;
    fs      = pend_r ? b0_r : ((b1_r != 4'd0) ? b1_r : b0_r);
    data_lo = in_data.resp_data & bmask(b0_r);
    old_lo  = in_data.resp_old_value & bmask(b0_r);
  end

  always_comb begin
    busy_nxt  = busy_r;
    pend_nxt  = pend_r;
    addr2_nxt = addr2_r;
    b0_nxt    = b0_r;
    b1_nxt    = b1_r;
    saved_nxt = saved_r;
    op_nxt    = op_r;
    sgn_nxt   = sgn_r;
    treg_nxt  = treg_r;
    areg_nxt  = areg_r;
    pc_nxt    = pc_r;
    cmd       = '0;
    cmd_valid = 1'b0;
    if (accept) begin
      if (in_data.req_type == REQ_CORE) begin
        cmd_valid = 1'b1;
        if (busy_r) begin
          cmd.kind = KIND_BUSY;
        end else begin
          busy_nxt  = 1'b1;
          op_nxt    = in_data.op_kind;
          sgn_nxt   = in_data.sign_ext;
          treg_nxt  = in_data.dest_reg;
          areg_nxt  = in_data.result_reg;
          pc_nxt    = in_data.pc;
          saved_nxt = in_data.store_data[RW-1:0];
          cmd.kind  = KIND_BEAT;
          cmd.addr  = 32'(a);
          cmd.op    = in_data.op_kind;
          cmd.d0    = 64'(in_data.store_data[RW-1:0]);
          if (split) begin
            pend_nxt  = 1'b1;
            addr2_nxt = ws_last;
            b0_nxt    = s0;
            b1_nxt    = sz - s0;
            cmd.size  = s0;
            cmd.split = 1'b1;
          end else begin
            pend_nxt  = 1'b0;
            addr2_nxt = a;
            b0_nxt    = sz;
            b1_nxt    = 4'd0;
            cmd.size  = sz;
          end
        end
      end else if (busy_r) begin
        cmd_valid = 1'b1;
        if (in_data.resp_error) begin
          busy_nxt = 1'b0;
          pend_nxt = 1'b0;
          cmd.kind = KIND_FAULT;
          cmd.pc   = pc_r;
          cmd.addr = 32'(fa);
          cmd.size = fs;
          cmd.op   = op_r;
        end else if (pend_r) begin
          // second beat: operand shifted down by the first-beat bytes in the back end
          pend_nxt  = 1'b0;
          cmd.kind  = KIND_BEAT;
          cmd.addr  = 32'(addr2_r);
          cmd.size  = b1_r;
          cmd.op    = op_r;
          cmd.d0    = 64'(saved_r);
          cmd.b0    = b0_r;
          cmd.split = 1'b1;
          if (op_r == OP_READ) begin
            saved_nxt = data_lo[RW-1:0];
          end else if (op_r != OP_WRITE) begin
            saved_nxt = old_lo[RW-1:0];
          end
        end else begin
          busy_nxt = 1'b0;
          if (op_r == OP_WRITE) begin
            cmd.kind = KIND_DONE;
          end else begin
            cmd.kind    = KIND_WB;
            cmd.reg_idx = (op_r == OP_READ) ? treg_r : areg_r;
            cmd.d0      = (op_r == OP_READ) ? in_data.resp_data : in_data.resp_old_value;
            cmd.d1      = 64'(saved_r);
            cmd.b0      = b0_r;
            cmd.b1      = b1_r;
            cmd.sgn     = sgn_r;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pend_r <= 1'b0;
      b0_r   <= 4'd0;
      b1_r   <= 4'd0;
    end else begin
      busy_r <= busy_nxt;
      pend_r <= pend_nxt;
      b0_r   <= b0_nxt;
      b1_r   <= b1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr2_r <= addr2_nxt;
    saved_r <= saved_nxt;
    op_r    <= op_nxt;
    sgn_r   <= sgn_nxt;
    treg_r  <= treg_nxt;
    areg_r  <= areg_nxt;
    pc_r    <= pc_nxt;
  end

  assign status.busy    = busy_r;
  assign status.pending = pend_r;

endmodule
`default_nettype wire

// ----- rtl/mlss_queue.sv -----
`default_nettype none
module mlss_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  mlss_pkg::cmd_t wr_cmd,
  output logic           full,
  input  logic           take,
  output mlss_pkg::cmd_t rd_cmd,
  output logic           empty
);
  import mlss_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          slot_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_take;

  assign full    = (count_r == CW'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_take = take && !empty;
  assign rd_cmd  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_take) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_take) begin
      count_nxt = count_r + CW'(1);
    end else if (!do_push && do_take) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= wr_cmd;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/mlss_back.sv -----
`default_nettype none
module mlss_back #(
  parameter int REG_BITS = mlss_pkg::REG_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mlss_pkg::cmd_t      cmd,
  input  logic                cmd_ready,
  output logic                take,
  input  logic                pop,
  output logic                empty,
  output mlss_pkg::out_item_t out_data
);
  import mlss_pkg::*;

  out_item_t   out_r, out_nxt;
  logic        valid_r, valid_nxt;
  logic [63:0] hi_part, merged, ext;
  logic [3:0]  total;

  assign take     = cmd_ready && (!valid_r || pop);
  assign empty    = !valid_r;
  assign out_data = out_r;

  // read and atomic merge: second-beat bytes above the kept first-beat bytes
  always_comb begin
    hi_part = cmd.d0 & bmask(cmd.b1);
    if (cmd.b1 != 4'd0) begin
      merged = (hi_part << {cmd.b0, 3'b000}) | (cmd.d1 & bmask(cmd.b0));
      total  = cmd.b0 + cmd.b1;
    end else begin
      merged = cmd.d0;
      total  = cmd.b0;
    end
    ext = extend_bytes(merged, total, cmd.sgn);
  end

  always_comb begin
    out_nxt = '0;
    case (cmd.kind)
      KIND_BEAT: begin
        out_nxt.out_kind  = KIND_BEAT;
        out_nxt.beat_addr = cmd.addr;
        out_nxt.beat_size = cmd.size;
        out_nxt.beat_op   = cmd.op;
        out_nxt.is_split  = cmd.split;
        out_nxt.beat_data = (cmd.op == OP_READ) ? 64'd0 :
                            ((cmd.d0 >> {cmd.b0, 3'b000}) & bmask(cmd.size));
      end
      KIND_WB: begin
        out_nxt.out_kind = KIND_WB;
        out_nxt.wb_reg   = cmd.reg_idx;
        out_nxt.wb_data  = 64'(ext[REG_BITS-1:0]);
      end
      KIND_DONE: begin
        out_nxt.out_kind = KIND_DONE;
      end
      KIND_FAULT: begin
        out_nxt.out_kind   = KIND_FAULT;
        out_nxt.fault_pc   = cmd.pc;
        out_nxt.fault_addr = cmd.addr;
        out_nxt.fault_size = cmd.size;
        out_nxt.fault_op   = cmd.op;
      end
      KIND_BUSY: begin
        out_nxt.out_kind = KIND_BUSY;
      end
      default: begin
        out_nxt = '0;
      end
    endcase
  end

  always_comb begin
    if (take) begin
      valid_nxt = 1'b1;
    end else if (pop) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_r <= out_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/misaligned_load_store_splitter.sv -----
// Load/store unit front end with one outstanding access and misaligned splitting.
// Input channel: push/full with in_data. A word is either a core access
// (req_type 0) or the bus response for the current beat (req_type 1).
// Result channel: empty/pop with out_data; each word is a bus beat, a register
// writeback, a write completion, a fault or a busy refusal.
// An access crossing a port word goes out as two beats; the second beat is
// issued by the response to the first, and the writeback by the response to the
// last beat. A response while idle produces no result word.
// The result of an accepted word passes through the command queue and then the
// output register, from which it can be popped.
// Throughput: one word per cycle while full is low; the decode and state update
// sit in the front stage, and the data shifting and extension in the back.
// The front and back are joined by a two-entry command queue; the back drives a
// single output register. When the receiver holds off pop, the output register
// keeps its word, the queue fills, and full rises after two more words.
// Reset (rst_n low, synchronous) returns the unit to idle with queue and output
// register empty.
`default_nettype none
module misaligned_load_store_splitter #(
  parameter int PORT_BYTES = mlss_pkg::PORT_BYTES_DEF,
  parameter int REG_BITS   = mlss_pkg::REG_BITS_DEF,
  parameter int ADDR_BITS  = mlss_pkg::ADDR_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  mlss_pkg::in_item_t  in_data,
  output logic                empty,
  input  logic                pop,
  output mlss_pkg::out_item_t out_data
);
  import mlss_pkg::*;

  logic          accept;
  cmd_t          f_cmd, q_cmd;
  logic          f_cmd_valid;
  logic          q_empty, q_take;
  front_status_t f_status;

  assign accept = push && !full;

  mlss_front #(
    .PORT_BYTES(PORT_BYTES),
    .REG_BITS  (REG_BITS),
    .ADDR_BITS (ADDR_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .in_data  (in_data),
    .cmd      (f_cmd),
    .cmd_valid(f_cmd_valid),
    .status   (f_status)
  );

  mlss_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_cmd_valid),
    .wr_cmd(f_cmd),
    .full  (full),
    .take  (q_take),
    .rd_cmd(q_cmd),
    .empty (q_empty)
  );

  mlss_back #(
    .REG_BITS(REG_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (q_cmd),
    .cmd_ready(!q_empty),
    .take     (q_take),
    .pop      (pop),
    .empty    (empty),
    .out_data (out_data)
  );

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.req_type == REQ_CORE && !f_status.busy) |=> f_status.busy)
    else $error("core access accepted while idle did not mark the unit busy");

  a_pend_busy: assert property (@(posedge clk) disable iff (!rst_n)
    f_status.pending |-> f_status.busy)
    else $error("second beat pending while the unit is idle");

  a_split_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (f_cmd_valid && f_cmd.kind == KIND_BEAT && f_cmd.split && !f_status.pending)
      |=> f_status.pending)
    else $error("first beat of a split access did not leave a second beat pending");

  a_refuse_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (f_cmd_valid && f_cmd.kind == KIND_BUSY) |-> f_status.busy)
    else $error("access refused while the unit is idle");

endmodule
`default_nettype wire

// ----- test/testbench.sv -----
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  import mlss_pkg::*;

  localparam logic [3:0] OP_AMO_FIRST = 4'd2;
  localparam logic [3:0] OP_AMO_LAST  = 4'd15;
  localparam int RAND_WORDS   = 1500;
  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 10;

  typedef enum logic [1:0] {ROW_PREDICT, ROW_TYPED, ROW_SILENT} row_check_t;

  typedef struct {
    in_item_t   w;
    row_check_t how;
    out_item_t  want;
  } script_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      push = 1'b0;
  logic      pop = 1'b0;
  logic      full;
  logic      empty;
  in_item_t  in_data = '0;
  out_item_t out_data;

  misaligned_load_store_splitter dut (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_data(in_data),
    .empty(empty), .pop(pop), .out_data(out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow copy of the unit's state
  bit        lsu_busy = 1'b0;
  bit        beat2_pending = 1'b0;
  bit [31:0] beat2_addr = '0;
  bit [3:0]  bytes0 = '0;
  bit [3:0]  bytes1 = '0;
  bit [63:0] held_value = '0;
  bit [3:0]  held_op = '0;
  bit        held_sgn = 1'b0;
  bit [4:0]  load_reg = '0;
  bit [4:0]  amo_reg = '0;
  bit [31:0] held_pc = '0;

  out_item_t   awaited_words[$];
  script_row_t access_script[$];

  int unsigned cycles = 0;
  bit          calm = 1'b0;
  int unsigned mismatches = 0;
  int unsigned words_checked = 0;
  int unsigned n_access = 0;
  int unsigned n_split = 0;
  int unsigned n_refused = 0;
  int unsigned n_fault = 0;
  int unsigned n_writeback = 0;
  int unsigned pop_left = 0;
  int unsigned pop_gap;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if ($urandom_range(0, 399) == 0) calm <= ~calm;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic bit [63:0] lane_mask(input int unsigned n);
    if (n >= 8) return '1;
    return (64'd1 << (n * 8)) - 64'd1;
  endfunction

  function automatic bit [63:0] widen(input bit [63:0] v, input int unsigned n, input bit sgn);
    bit [63:0] m;
    m = lane_mask(n);
    v = v & m;
    if (sgn && n > 0 && n < 8 && v[n * 8 - 1]) v = v | ~m;
    return v;
  endfunction

  function automatic bit [31:0] port_base(input bit [31:0] a);
    return a - (a % 32'(PORT_BYTES_DEF));
  endfunction

  function automatic void put_beat(output out_item_t r, input bit [31:0] a,
                                   input int unsigned n, input bit [3:0] op,
                                   input bit [63:0] data, input bit split);
    r = '0;
    r.out_kind  = KIND_BEAT;
    r.beat_addr = a;
    r.beat_size = 4'(n);
    r.beat_op   = op;
    r.beat_data = (op == OP_READ) ? 64'd0 : (data & lane_mask(n));
    r.is_split  = split;
  endfunction

  // returns 1 when the word produces a result word
  function automatic bit predict_lsu(input in_item_t w, output out_item_t r);
    bit [31:0]   a, a1, d;
    int unsigned sz, s0, total;
    bit [63:0]   raw, v;
    r = '0;
    if (w.req_type == REQ_CORE) begin
      if (lsu_busy) begin
        r.out_kind = KIND_BUSY;
        n_refused++;
        return 1;
      end
      sz = 32'(w.size);
      if (sz == 0) sz = 1;
      if (sz > 8) sz = 8;
      a  = w.addr;
      a1 = port_base(a + 32'(sz) - 32'd1);
      s0 = 0;
      if (port_base(a) != a1) begin
        d = a1 - a;
        if (d != 0 && d < sz) s0 = d;
      end
      lsu_busy   = 1'b1;
      held_op    = w.op_kind;
      held_sgn   = w.sign_ext;
      load_reg   = w.dest_reg;
      amo_reg    = w.result_reg;
      held_pc    = w.pc;
      held_value = w.store_data;
      n_access++;
      if (s0 != 0) begin
        beat2_pending = 1'b1;
        beat2_addr    = a1;
        bytes0        = 4'(s0);
        bytes1        = 4'(sz - s0);
        put_beat(r, a, s0, w.op_kind, w.store_data, 1'b1);
        n_split++;
      end else begin
        beat2_pending = 1'b0;
        beat2_addr    = a;
        bytes0        = 4'(sz);
        bytes1        = '0;
        put_beat(r, a, sz, w.op_kind, w.store_data, 1'b0);
      end
      return 1;
    end

    if (!lsu_busy) return 0;

    if (w.resp_error) begin
      r.out_kind = KIND_FAULT;
      r.fault_pc = held_pc;
      r.fault_op = held_op;
      if (beat2_pending) begin
        r.fault_addr = beat2_addr - 32'(bytes0);
        r.fault_size = bytes0;
      end else begin
        r.fault_addr = beat2_addr;
        r.fault_size = (bytes1 != 0) ? bytes1 : bytes0;
      end
      lsu_busy      = 1'b0;
      beat2_pending = 1'b0;
      n_fault++;
      return 1;
    end

    if (beat2_pending) begin
      put_beat(r, beat2_addr, 32'(bytes1), held_op,
               (held_op != OP_READ) ? (held_value >> (bytes0 * 8)) : 64'd0, 1'b1);
      // keep the low bytes of beat 0 for the merge
      if (held_op == OP_READ) held_value = w.resp_data & lane_mask(32'(bytes0));
      else if (held_op != OP_WRITE) held_value = w.resp_old_value & lane_mask(32'(bytes0));
      beat2_pending = 1'b0;
      return 1;
    end

    lsu_busy = 1'b0;
    if (held_op == OP_WRITE) begin
      r.out_kind = KIND_DONE;
      return 1;
    end
    raw = (held_op == OP_READ) ? w.resp_data : w.resp_old_value;
    if (bytes1 != 0) begin
      v = ((raw & lane_mask(32'(bytes1))) << (bytes0 * 8)) |
          (held_value & lane_mask(32'(bytes0)));
      total = 32'(bytes0) + 32'(bytes1);
    end else begin
      v = raw;
      total = 32'(bytes0);
    end
    r.out_kind = KIND_WB;
    r.wb_reg   = (held_op == OP_READ) ? load_reg : amo_reg;
    r.wb_data  = widen(v, total, held_sgn);
    n_writeback++;
    return 1;
  endfunction

  function automatic in_item_t core_word(input bit [31:0] a, input bit [3:0] sz,
                                         input bit [3:0] op, input bit sgn,
                                         input bit [4:0] dreg, input bit [4:0] rreg,
                                         input bit [63:0] data, input bit [31:0] pc);
    in_item_t w;
    w = '0;
    w.req_type   = REQ_CORE;
    w.addr       = a;
    w.size       = sz;
    w.op_kind    = op;
    w.sign_ext   = sgn;
    w.dest_reg   = dreg;
    w.result_reg = rreg;
    w.store_data = data;
    w.pc         = pc;
    return w;
  endfunction

  function automatic in_item_t reply_word(input bit [63:0] data, input bit [63:0] old,
                                          input bit err);
    in_item_t w;
    w = '0;
    w.req_type       = REQ_RESP;
    w.resp_data      = data;
    w.resp_old_value = old;
    w.resp_error     = err;
    return w;
  endfunction

  function automatic in_item_t random_word(input bit is_reply, input bit err);
    in_item_t w;
    w.req_type       = is_reply ? REQ_RESP : REQ_CORE;
    w.addr           = ($urandom_range(0, 4) == 0) ? (32'hFFFF_FFF8 | 32'($urandom_range(0, 7)))
                                                   : 32'($urandom);
    w.size           = ($urandom_range(0, 6) == 0) ? 4'($urandom_range(0, 15))
                                                   : 4'($urandom_range(1, 8));
    w.op_kind        = ($urandom_range(0, 9) < 4) ? OP_READ :
                       ($urandom_range(0, 9) < 5) ? OP_WRITE :
                       4'($urandom_range(OP_AMO_FIRST, OP_AMO_LAST));
    w.sign_ext       = 1'($urandom_range(0, 1));
    w.dest_reg       = 5'($urandom_range(0, 31));
    w.result_reg     = 5'($urandom_range(0, 31));
    w.store_data     = {$urandom, $urandom};
    w.pc             = $urandom;
    w.resp_data      = {$urandom, $urandom};
    w.resp_old_value = {$urandom, $urandom};
    w.resp_error     = is_reply ? err : 1'($urandom_range(0, 1));
    return w;
  endfunction

  function automatic void add_row(input in_item_t w, input row_check_t how,
                                  input out_item_t want);
    script_row_t row;
    row.w    = w;
    row.how  = how;
    row.want = want;
    access_script.insert(access_script.size(), row);
  endfunction

  // called at a rising edge; returns at the edge that takes the word
  task automatic offer_word(input in_item_t w);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push    <= 1'b1;
    in_data <= w;
    do @(negedge clk); while (full);
    @(posedge clk);
  endtask

  task automatic note_field(input string name, input logic [63:0] want,
                            input logic [63:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch in %s of result word %0d: expected %h, got %h",
                 name, words_checked, want, got);
    end
  endtask

  // receiver side: pop runs and stalls of random length
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else if (pop_left != 0) begin
      pop_left <= pop_left - 1;
    end else begin
      pop_gap = pick_gap();
      if (pop && pop_gap != 0) begin
        pop      <= 1'b0;
        pop_left <= pop_gap - 1;
      end else begin
        pop      <= 1'b1;
        pop_left <= $urandom_range(0, 24);
      end
    end
  end

  // a word taken at the next edge is checked here
  always @(negedge clk) begin
    out_item_t want;
    if (rst_n && pop && !empty) begin
      if (awaited_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word %0d: %h", words_checked, out_data);
      end else begin
        want = awaited_words.pop_front();
        note_field("out_kind", 64'(want.out_kind), 64'(out_data.out_kind));
        note_field("beat_addr", 64'(want.beat_addr), 64'(out_data.beat_addr));
        note_field("beat_size", 64'(want.beat_size), 64'(out_data.beat_size));
        note_field("beat_op", 64'(want.beat_op), 64'(out_data.beat_op));
        note_field("beat_data", want.beat_data, out_data.beat_data);
        note_field("is_split", 64'(want.is_split), 64'(out_data.is_split));
        note_field("wb_reg", 64'(want.wb_reg), 64'(out_data.wb_reg));
        note_field("wb_data", want.wb_data, out_data.wb_data);
        note_field("fault_pc", 64'(want.fault_pc), 64'(out_data.fault_pc));
        note_field("fault_addr", 64'(want.fault_addr), 64'(out_data.fault_addr));
        note_field("fault_size", 64'(want.fault_size), 64'(out_data.fault_size));
        note_field("fault_op", 64'(want.fault_op), 64'(out_data.fault_op));
      end
      words_checked++;
    end
  end

  initial begin
    while (cycles < LIMIT_CYCLES) @(posedge clk);
    $display("timeout after %0d cycles, %0d result words still awaited",
             cycles, awaited_words.size());
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    out_item_t   fx;
    out_item_t   p;
    out_item_t   none;
    in_item_t    w;
    bit          has_word;
    bit          ignored;
    int unsigned r;
    int unsigned n_rand;

    none = '0;
    add_row(reply_word('0, '0, 1'b0), ROW_SILENT, none);          // response while idle
    fx = '0;
    fx.out_kind  = KIND_BEAT;
    fx.beat_addr = 32'h0000_1000;
    fx.beat_size = 4'd4;
    fx.beat_op   = OP_READ;
    add_row(core_word(32'h1000, 4'd4, OP_READ, 1'b1, 5'd5, 5'd0, '0, 32'h100), ROW_TYPED, fx);
    fx = '0;
    fx.out_kind = KIND_BUSY;
    add_row(core_word(32'h2000, 4'd8, OP_WRITE, 1'b0, 5'd3, 5'd4, '1, 32'h104), ROW_TYPED, fx);
    add_row(reply_word(64'h1234_5678_8000_00F0, '0, 1'b0), ROW_PREDICT, none);
    // write wrapping past the top of the address space
    add_row(core_word(32'hFFFF_FFFE, 4'd8, OP_WRITE, 1'b0, 5'd31, 5'd0,
                      64'h0123_4567_89AB_CDEF, 32'h108), ROW_PREDICT, none);
    add_row(reply_word('0, '0, 1'b0), ROW_PREDICT, none);
    fx = '0;
    fx.out_kind = KIND_DONE;
    add_row(reply_word('0, '0, 1'b0), ROW_TYPED, fx);
    // size zero atomic, error on its only beat
    add_row(core_word(32'h3, 4'd0, OP_AMO_LAST, 1'b1, 5'd0, 5'd7, '1, 32'hDEAD_BEEC),
            ROW_PREDICT, none);
    fx = '0;
    fx.out_kind   = KIND_FAULT;
    fx.fault_pc   = 32'hDEAD_BEEC;
    fx.fault_addr = 32'h3;
    fx.fault_size = 4'd1;
    fx.fault_op   = OP_AMO_LAST;
    add_row(reply_word('0, '0, 1'b1), ROW_TYPED, fx);
    // oversize read over three port words, error on beat zero
    add_row(core_word(32'h1, 4'd15, OP_READ, 1'b1, 5'd9, 5'd0, '0, 32'h10C), ROW_PREDICT, none);
    add_row(reply_word('1, '1, 1'b1), ROW_PREDICT, none);
    // split atomic with sign-extended old value
    add_row(core_word(32'h2, 4'd4, OP_AMO_FIRST, 1'b1, 5'd1, 5'd31,
                      64'hAAAA_5555_AAAA_5555, 32'hFFFF_FFFF), ROW_PREDICT, none);
    add_row(reply_word('0, 64'h1111_2222_3333_8844, 1'b0), ROW_PREDICT, none);
    add_row(reply_word('0, 64'h0000_0000_0000_80FF, 1'b0), ROW_PREDICT, none);
    // split read at the last byte, error on beat one
    add_row(core_word(32'hFFFF_FFFF, 4'd2, OP_READ, 1'b0, 5'd2, 5'd0, '0, 32'h110),
            ROW_PREDICT, none);
    add_row(reply_word(64'h55, '0, 1'b0), ROW_PREDICT, none);
    add_row(reply_word('0, '0, 1'b1), ROW_PREDICT, none);
    add_row(core_word(32'h0, 4'd8, OP_WRITE, 1'b0, 5'd31, 5'd31, '1, '1), ROW_PREDICT, none);
    add_row(reply_word('1, '1, 1'b0), ROW_PREDICT, none);
    add_row(reply_word('1, '1, 1'b0), ROW_PREDICT, none);
    // one byte into register zero
    add_row(core_word(32'h0, 4'd1, OP_READ, 1'b0, 5'd0, 5'd0, '0, '0), ROW_PREDICT, none);
    add_row(reply_word('1, '0, 1'b0), ROW_PREDICT, none);
    add_row(reply_word('0, '0, 1'b1), ROW_SILENT, none);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (access_script[i]) begin
      offer_word(access_script[i].w);
      has_word = predict_lsu(access_script[i].w, p);
      case (access_script[i].how)
        ROW_PREDICT: if (has_word) awaited_words.insert(awaited_words.size(), p);
        ROW_TYPED:   awaited_words.insert(awaited_words.size(), access_script[i].want);
        default:     ;
      endcase
    end

    // mostly complete accesses, with refusals, errors and stray responses mixed in
    n_rand = 0;
    while (n_rand < RAND_WORDS) begin
      ignored = 1'b0;
      if (!lsu_busy) begin
        ignored = ($urandom_range(0, 19) == 0);
        w = random_word(ignored, 1'($urandom_range(0, 1)));
      end else begin
        r = $urandom_range(0, 99);
        w = random_word(r >= 6, r < 10);
      end
      offer_word(w);
      if (predict_lsu(w, p)) awaited_words.insert(awaited_words.size(), p);
      if (!ignored) n_rand++;
    end
    push <= 1'b0;

    while (awaited_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("ran %0d accesses (%0d split), %0d refused while busy, %0d faults, %0d writebacks",
             n_access, n_split, n_refused, n_fault, n_writeback);
    $display("checked %0d result words, %0d mismatches", words_checked, mismatches);
    if (mismatches == 0 && awaited_words.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
